>>> src/vector_cosine_similarity_core_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the cosine similarity core
// ---------------------------------------------------------------------------
`ifndef VECTOR_COSINE_SIMILARITY_CORE_ASSERT_SVH
`define VECTOR_COSINE_SIMILARITY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define VCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcs assertion failed");

// next-cycle implication, disabled during reset
`define VCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcs assertion failed");

`else

`define VCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/vcs_pkg.sv
// ---------------------------------------------------------------------------
// vcs_pkg
// shared widths and types of the cosine similarity core
// ---------------------------------------------------------------------------
package vcs_pkg;

    // element and sum widths
    localparam int DATA_W  = 16;
    localparam int DOT_W   = 48;
    localparam int NORM_W  = 47;
    localparam int PAB_W   = 2 * DATA_W;
    localparam int PSQ_W   = 2 * DATA_W - 1;

    // cosine unit widths
    localparam int HALF_W  = 24;
    localparam int WORD_W  = 2 * HALF_W;
    localparam int PROD_W  = 2 * NORM_W;
    localparam int MSQ_W   = 2 * WORD_W;
    localparam int CMP_W   = 128;
    localparam int FRAC_SH = 30;
    localparam int Q_W     = 16;

    // queue between accumulator and cosine unit
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // finished sums of one vector pair
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       na;
        logic [NORM_W-1:0]       nb;
    } t_sums;

endpackage

>>> src/vector_cosine_similarity_core.sv
// an element pair reaches the accumulators in the cycle after its beat; the sums of a last
// beat pass the queue to the cosine unit, which skips its multiply and search steps for a
// zero-norm vector; throughput: one element pair per cycle while the queue has room; the
// cosine unit works on one vector at a time (9 shared-multiplier steps, 32 search steps),
// so short vectors stall on the 2-entry queue
// reset: synchronous, active low; clears the sums, the queue and the output register
// ---------------------------------------------------------------------------
// vector_cosine_similarity_core
// streaming cosine similarity of two Q1.15 vectors with saturating sums
// ---------------------------------------------------------------------------
module vector_cosine_similarity_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [vcs_pkg::DATA_W-1:0]   i_a_value,
    input  logic signed [vcs_pkg::DATA_W-1:0]   i_b_value,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [vcs_pkg::DATA_W-1:0]   o_cosine,
    output logic                                o_degenerate
);

    logic                            w_push;
    vcs_pkg::t_sums                  w_push_data;
    logic                            w_pop;
    vcs_pkg::t_sums                  w_pop_data;
    logic                            w_not_empty;
    logic [vcs_pkg::FIFO_CW-1:0]     w_count;

    // accumulator
    vcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_a_value    (i_a_value),
        .i_b_value    (i_b_value),
        .i_last       (i_last),
        .i_fifo_count (w_count),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // queue of finished sums
    vcs_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_push_data),
        .i_pop       (w_pop),
        .o_data      (w_pop_data),
        .o_not_empty (w_not_empty),
        .o_count     (w_count)
    );

    // cosine unit
    vcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_not_empty),
        .i_sums       (w_pop_data),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cosine     (o_cosine),
        .o_degenerate (o_degenerate)
    );

endmodule

>>> src/vcs_front.sv
// ---------------------------------------------------------------------------
// vcs_front
// accepts element pairs, squares and multiplies them, keeps saturating sums
// and hands the finished sums of each vector to the queue
// ---------------------------------------------------------------------------
module vcs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [vcs_pkg::DATA_W-1:0]   i_a_value,
    input  logic signed [vcs_pkg::DATA_W-1:0]   i_b_value,
    input  logic                                i_last,
    input  logic [vcs_pkg::FIFO_CW-1:0]         i_fifo_count,
    output logic                                o_push,
    output vcs_pkg::t_sums                      o_push_data
);

    logic                                r_s1_valid;
    logic                                r_s1_last;
    logic signed [vcs_pkg::PAB_W-1:0]    r_pab;
    logic [vcs_pkg::PSQ_W-1:0]           r_paa;
    logic [vcs_pkg::PSQ_W-1:0]           r_pbb;
    logic signed [vcs_pkg::DOT_W-1:0]    r_dot;
    logic [vcs_pkg::NORM_W-1:0]          r_na;
    logic [vcs_pkg::NORM_W-1:0]          r_nb;

    logic                                w_accept;
    logic [vcs_pkg::FIFO_CW:0]           w_reserved;
    logic signed [vcs_pkg::PAB_W-1:0]    w_ab;
    logic signed [vcs_pkg::PAB_W-1:0]    w_aa;
    logic signed [vcs_pkg::PAB_W-1:0]    w_bb;
    logic signed [vcs_pkg::DOT_W:0]      w_dot_sum;
    logic [vcs_pkg::NORM_W:0]            w_na_sum;
    logic [vcs_pkg::NORM_W:0]            w_nb_sum;
    vcs_pkg::t_sums                      w_next;

    // a queue slot is held for a last beat still in the product stage
    assign w_reserved = (vcs_pkg::FIFO_CW+1)'(i_fifo_count)
                      + (vcs_pkg::FIFO_CW+1)'(r_s1_valid & r_s1_last);
    assign o_in_ready = (w_reserved < (vcs_pkg::FIFO_CW+1)'(vcs_pkg::FIFO_DEPTH));
    assign w_accept   = i_in_valid & o_in_ready;

    // element products
    assign w_ab = i_a_value * i_b_value;
    assign w_aa = i_a_value * i_a_value;
    assign w_bb = i_b_value * i_b_value;

    // saturating sums
    assign w_dot_sum = (vcs_pkg::DOT_W+1)'(r_dot) + (vcs_pkg::DOT_W+1)'(r_pab);
    assign w_na_sum  = (vcs_pkg::NORM_W+1)'(r_na) + (vcs_pkg::NORM_W+1)'(r_paa);
    assign w_nb_sum  = (vcs_pkg::NORM_W+1)'(r_nb) + (vcs_pkg::NORM_W+1)'(r_pbb);

    always_comb begin
        if (w_dot_sum[vcs_pkg::DOT_W] != w_dot_sum[vcs_pkg::DOT_W-1]) begin
            w_next.dot = w_dot_sum[vcs_pkg::DOT_W] ?
                         {1'b1, {(vcs_pkg::DOT_W-1){1'b0}}} :
                         {1'b0, {(vcs_pkg::DOT_W-1){1'b1}}};
        end else begin
            w_next.dot = w_dot_sum[vcs_pkg::DOT_W-1:0];
        end
        w_next.na = w_na_sum[vcs_pkg::NORM_W] ? '1 : w_na_sum[vcs_pkg::NORM_W-1:0];
        w_next.nb = w_nb_sum[vcs_pkg::NORM_W] ? '1 : w_nb_sum[vcs_pkg::NORM_W-1:0];
    end

    assign o_push      = r_s1_valid & r_s1_last;
    assign o_push_data = w_next;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_last <= i_last;
            r_pab     <= w_ab;
            r_paa     <= w_aa[vcs_pkg::PSQ_W-1:0];
            r_pbb     <= w_bb[vcs_pkg::PSQ_W-1:0];
        end
    end

    // accumulators, cleared after the last beat of a vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
            end else begin
                r_dot <= w_next.dot;
                r_na  <= w_next.na;
                r_nb  <= w_next.nb;
            end
        end
    end

endmodule

>>> src/vcs_fifo.sv
// ---------------------------------------------------------------------------
// vcs_fifo
// short queue of finished sums between accumulator and cosine unit
// ---------------------------------------------------------------------------
module vcs_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  vcs_pkg::t_sums                i_data,
    input  logic                          i_pop,
    output vcs_pkg::t_sums                o_data,
    output logic                          o_not_empty,
    output logic [vcs_pkg::FIFO_CW-1:0]   o_count
);

    vcs_pkg::t_sums                   r_mem [vcs_pkg::FIFO_DEPTH];
    logic [vcs_pkg::FIFO_AW-1:0]      r_wr_ptr;
    logic [vcs_pkg::FIFO_AW-1:0]      r_rd_ptr;
    logic [vcs_pkg::FIFO_CW-1:0]      r_count;

    assign o_data      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/vcs_back.sv
// ---------------------------------------------------------------------------
// vcs_back
// cosine unit: forms the norm product and squared dot with one shared
// 24x24 multiplier, then finds the quotient bit by bit and drives the output
// ---------------------------------------------------------------------------
`include "vector_cosine_similarity_core_assert.svh"

module vcs_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pop_valid,
    input  vcs_pkg::t_sums                      i_sums,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [vcs_pkg::DATA_W-1:0]   o_cosine,
    output logic                                o_degenerate
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CAND,
        S_CMP,
        S_DONE
    } t_state;

    localparam logic [3:0] MUL_LAST = 4'd8;
    localparam logic [3:0] K_TOP    = 4'(vcs_pkg::Q_W - 1);

    // control and output registers
    t_state                              r_state, n_state;
    logic                                r_out_valid, n_out_valid;
    logic signed [vcs_pkg::DATA_W-1:0]   r_out_cosine, n_out_cosine;
    logic                                r_out_degen, n_out_degen;

    // datapath registers
    logic                                r_neg, n_neg;
    logic                                r_degen, n_degen;
    logic [vcs_pkg::WORD_W-1:0]          r_mag, n_mag;
    logic [vcs_pkg::NORM_W-1:0]          r_na, n_na;
    logic [vcs_pkg::NORM_W-1:0]          r_nb, n_nb;
    logic [3:0]                          r_cnt, n_cnt;
    logic [2:0]                          r_pidx, n_pidx;
    logic [vcs_pkg::WORD_W-1:0]          r_pp, n_pp;
    logic [vcs_pkg::PROD_W-1:0]          r_p, n_p;
    logic [vcs_pkg::MSQ_W-1:0]           r_m, n_m;
    logic [vcs_pkg::CMP_W-1:0]           r_y, n_y;
    logic [vcs_pkg::CMP_W-1:0]           r_z, n_z;
    logic [vcs_pkg::CMP_W-1:0]           r_cand, n_cand;
    logic [vcs_pkg::Q_W-1:0]             r_q, n_q;
    logic [3:0]                          r_k, n_k;

    logic [2:0]                          w_idx;
    logic [vcs_pkg::WORD_W-1:0]          w_x, w_y;
    logic [vcs_pkg::HALF_W-1:0]          w_xp, w_yp;
    logic [vcs_pkg::WORD_W-1:0]          w_mul;
    logic [5:0]                          w_sh;
    logic [vcs_pkg::MSQ_W-1:0]           w_term;
    logic [vcs_pkg::CMP_W-1:0]           w_d;
    logic [vcs_pkg::CMP_W-1:0]           w_pext;
    logic [4:0]                          w_k1;
    logic                                w_load;
    logic signed [vcs_pkg::DATA_W-1:0]   w_result;

    // shared multiplier: which halves go in at this step
    assign w_idx = r_cnt[2:0];
    assign w_x   = w_idx[2] ? r_mag : vcs_pkg::WORD_W'(r_na);
    assign w_y   = w_idx[2] ? r_mag : vcs_pkg::WORD_W'(r_nb);
    assign w_xp  = w_idx[1] ? w_x[vcs_pkg::WORD_W-1:vcs_pkg::HALF_W]
                            : w_x[vcs_pkg::HALF_W-1:0];
    assign w_yp  = w_idx[0] ? w_y[vcs_pkg::WORD_W-1:vcs_pkg::HALF_W]
                            : w_y[vcs_pkg::HALF_W-1:0];
    assign w_mul = w_xp * w_yp;

    // weight of the partial product from the previous step
    always_comb begin
        case (r_pidx[1:0])
            2'b00:   w_sh = 6'd0;
            2'b11:   w_sh = 6'(2 * vcs_pkg::HALF_W);
            default: w_sh = 6'(vcs_pkg::HALF_W);
        endcase
    end
    assign w_term = vcs_pkg::MSQ_W'(r_pp) << w_sh;

    // search operands
    assign w_d    = vcs_pkg::CMP_W'(r_m) << vcs_pkg::FRAC_SH;
    assign w_pext = vcs_pkg::CMP_W'(r_p);
    assign w_k1   = {1'b0, r_k} + 5'd1;

    // signed, clamped result
    always_comb begin
        if (r_q[vcs_pkg::Q_W-1]) begin
            w_result = r_neg ? {1'b1, {(vcs_pkg::DATA_W-1){1'b0}}}
                             : {1'b0, {(vcs_pkg::DATA_W-1){1'b1}}};
        end else begin
            w_result = r_neg ? -$signed(r_q) : $signed(r_q);
        end
    end

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_pop  = (r_state == S_IDLE) && i_pop_valid;

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_cosine = r_out_cosine;
        n_out_degen  = r_out_degen;
        n_neg        = r_neg;
        n_degen      = r_degen;
        n_mag        = r_mag;
        n_na         = r_na;
        n_nb         = r_nb;
        n_cnt        = r_cnt;
        n_pidx       = r_pidx;
        n_pp         = r_pp;
        n_p          = r_p;
        n_m          = r_m;
        n_y          = r_y;
        n_z          = r_z;
        n_cand       = r_cand;
        n_q          = r_q;
        n_k          = r_k;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_neg   = i_sums.dot[vcs_pkg::DOT_W-1];
                    n_mag   = n_neg ? vcs_pkg::WORD_W'(-i_sums.dot)
                                    : vcs_pkg::WORD_W'(i_sums.dot);
                    n_na    = i_sums.na;
                    n_nb    = i_sums.nb;
                    n_degen = (i_sums.na == '0) || (i_sums.nb == '0);
                    n_cnt   = '0;
                    n_p     = '0;
                    n_m     = '0;
                    n_y     = '0;
                    n_z     = '0;
                    n_q     = '0;
                    n_k     = K_TOP;
                    if (n_degen) begin
                        n_neg   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                // issue one partial product, add in the previous one
                if (r_cnt != MUL_LAST) begin
                    n_pp   = w_mul;
                    n_pidx = w_idx;
                end
                if (r_cnt != '0) begin
                    if (r_pidx[2]) begin
                        n_m = r_m + w_term;
                    end else begin
                        n_p = r_p + vcs_pkg::PROD_W'(w_term);
                    end
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                // (q + 2^k)^2 * P from q^2 * P and q * P
                n_cand  = r_y + (r_z << w_k1) + (w_pext << {r_k, 1'b0});
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_cand <= w_d) begin
                    n_q[r_k] = 1'b1;
                    n_y      = r_cand;
                    n_z      = r_z + (w_pext << r_k);
                end
                if (r_k == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k - 4'd1;
                    n_state = S_CAND;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_cosine = w_result;
                    n_out_degen  = r_degen;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_out_cosine <= '0;
            r_out_degen  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_out_cosine <= n_out_cosine;
            r_out_degen  <= n_out_degen;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_degen <= n_degen;
        r_mag  <= n_mag;
        r_na   <= n_na;
        r_nb   <= n_nb;
        r_cnt  <= n_cnt;
        r_pidx <= n_pidx;
        r_pp   <= n_pp;
        r_p    <= n_p;
        r_m    <= n_m;
        r_y    <= n_y;
        r_z    <= n_z;
        r_cand <= n_cand;
        r_q    <= n_q;
        r_k    <= n_k;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cosine     = r_out_cosine;
    assign o_degenerate = r_out_degen;

    // checks
    `VCS_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, r_out_valid && r_out_degen, r_out_cosine == '0)
    `VCS_ASSERT_NEXT(a_search_end, i_clk, i_rst_n, r_state == S_CMP && r_k == '0, r_state == S_DONE)
    `VCS_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, r_state == S_IDLE && i_pop_valid, r_state != S_IDLE)
    `VCS_ASSERT_IMPL(a_mul_count, i_clk, i_rst_n, r_state == S_MUL, r_cnt <= MUL_LAST)

endmodule

>>> sim/vector_cosine_similarity_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vector_cosine_similarity_core_tb
// streams element pairs into the cosine similarity core and checks every result
// against an exact integer predictor or, for obvious directed rows, a typed result:
// directed extremes and zero-norm vectors first, then random vectors under three idling mixes
// ---------------------------------------------------------------------------
module vector_cosine_similarity_core_tb;

    // saturation limits of the running sums
    localparam longint DOT_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DOT_LO  = -64'sh0000_8000_0000_0000;
    localparam longint NORM_HI = 64'sh0000_7FFF_FFFF_FFFF;

    localparam int PHASE_BEATS = 470;
    localparam int DIR_ROWS    = 24;

    // shape of one random vector pair
    typedef enum int {
        SHAPE_FREE,
        SHAPE_ZERO_A,
        SHAPE_ZERO_B,
        SHAPE_SAME,
        SHAPE_NEGATED,
        SHAPE_NEAR
    } t_vec_shape;

    typedef struct packed {
        logic signed [vcs_pkg::DATA_W-1:0] cosine;
        logic                              degenerate;
    } t_cos_result;

    // directed row: pair, last flag, and a typed result where obvious
    typedef struct packed {
        logic signed [vcs_pkg::DATA_W-1:0] a;
        logic signed [vcs_pkg::DATA_W-1:0] b;
        logic                              lst;
        logic                              typed;
        logic signed [vcs_pkg::DATA_W-1:0] cosine;
        logic                              degenerate;
    } t_dir_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic signed [vcs_pkg::DATA_W-1:0]   i_a_value;
    logic signed [vcs_pkg::DATA_W-1:0]   i_b_value;
    logic                                i_last;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic signed [vcs_pkg::DATA_W-1:0]   o_cosine;
    logic                                o_degenerate;

    // predictor sums
    longint dot_acc;
    longint norm_a_acc;
    longint norm_b_acc;

    t_cos_result pending_results[$];
    int          err_count;
    int          beat_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{16'sd0,      16'sd0,      1'b1, 1'b1, 16'sd0,      1'b1},
        '{16'sh7FFF,   16'sd0,      1'b1, 1'b1, 16'sd0,      1'b1},
        '{16'sd0,      16'sh8000,   1'b1, 1'b1, 16'sd0,      1'b1},
        '{16'sh8000,   16'sh8000,   1'b1, 1'b1, 16'sh7FFF,   1'b0},
        '{16'sh7FFF,   16'sh7FFF,   1'b1, 1'b1, 16'sh7FFF,   1'b0},
        '{16'sh7FFF,   -16'sd32767, 1'b1, 1'b1, 16'sh8000,   1'b0},
        '{16'sh8000,   16'sh7FFF,   1'b1, 1'b1, 16'sh8000,   1'b0},
        '{16'sd1,      -16'sd1,     1'b1, 1'b1, 16'sh8000,   1'b0},
        '{16'sd1,      16'sh7FFF,   1'b1, 1'b1, 16'sh7FFF,   1'b0},
        '{16'sd1,      16'sd1,      1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sd1,      -16'sd1,     1'b1, 1'b1, 16'sd0,      1'b0},
        '{16'sd16384,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sd0,      16'sd16384,  1'b1, 1'b1, 16'sd0,      1'b0},
        '{16'sd0,      16'sd5,      1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sd0,      -16'sd5,     1'b1, 1'b1, 16'sd0,      1'b1},
        '{16'sh8000,   16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sh8000,   16'sh8000,   1'b1, 1'b1, 16'sh7FFF,   1'b0},
        '{16'sd3,      16'sd4,      1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sd4,      16'sd3,      1'b1, 1'b0, 16'sd0,      1'b0},
        '{16'sd21845,  -16'sd21846, 1'b0, 1'b0, 16'sd0,      1'b0},
        '{-16'sd21846, 16'sd21845,  1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sd12345,  -16'sd23456, 1'b1, 1'b0, 16'sd0,      1'b0},
        '{-16'sd1,     16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
        '{16'sh7FFF,   16'sd1,      1'b1, 1'b0, 16'sd0,      1'b0}
    };

    vector_cosine_similarity_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_a_value    (i_a_value),
        .i_b_value    (i_b_value),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cosine     (o_cosine),
        .o_degenerate (o_degenerate)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #(64'd20_000_000);
        $display("tb: failure");
        $finish;
    end

    // largest q below 2^16 with q^2 * na * nb <= mag^2 * 2^30
    function automatic int cosine_magnitude(input longint mag, input longint na,
                                            input longint nb);
        logic [127:0] wa;
        logic [127:0] wb;
        logic [127:0] prod;
        logic [127:0] bound;
        logic [127:0] lhs;
        logic [31:0]  t2;
        int           q;
        int           t;
        wa    = na;
        wb    = nb;
        prod  = wa * wb;
        wa    = mag;
        bound = (wa * wa) << vcs_pkg::FRAC_SH;
        q     = 0;
        for (int k = 15; k >= 0; k--) begin
            t   = q | (1 << k);
            t2  = t * t;
            lhs = t2;
            lhs = lhs * prod;
            if (lhs <= bound) q = t;
        end
        return q;
    endfunction

    // fold one pair into the sums; returns 1 with the cosine on a last beat
    function automatic bit accumulate_pair(input logic signed [vcs_pkg::DATA_W-1:0] a,
                                           input logic signed [vcs_pkg::DATA_W-1:0] b,
                                           input logic lst,
                                           output t_cos_result res);
        longint d;
        longint mag;
        int     q;
        int     c;
        d = dot_acc + longint'(a) * longint'(b);
        if (d > DOT_HI) d = DOT_HI;
        if (d < DOT_LO) d = DOT_LO;
        dot_acc = d;
        norm_a_acc = norm_a_acc + longint'(a) * longint'(a);
        if (norm_a_acc > NORM_HI) norm_a_acc = NORM_HI;
        norm_b_acc = norm_b_acc + longint'(b) * longint'(b);
        if (norm_b_acc > NORM_HI) norm_b_acc = NORM_HI;
        res.cosine     = '0;
        res.degenerate = 1'b0;
        if (!lst) return 1'b0;
        if (norm_a_acc == 0 || norm_b_acc == 0) begin
            res.degenerate = 1'b1;
        end else begin
            mag = (dot_acc < 0) ? -dot_acc : dot_acc;
            q   = cosine_magnitude(mag, norm_a_acc, norm_b_acc);
            if (dot_acc < 0) begin
                c = -q;
                if (c < -32768) c = -32768;
            end else begin
                c = q;
                if (c > 32767) c = 32767;
            end
            res.cosine = c[vcs_pkg::DATA_W-1:0];
        end
        dot_acc    = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        return 1'b1;
    endfunction

    // drive one beat from a falling edge, wait for acceptance, predict
    task automatic send_beat(input logic signed [vcs_pkg::DATA_W-1:0] a,
                             input logic signed [vcs_pkg::DATA_W-1:0] b,
                             input logic lst, input logic typed,
                             input t_cos_result typed_res);
        t_cos_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_a_value  = a;
        i_b_value  = b;
        i_last     = lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beat_count++;
        if (accumulate_pair(a, b, lst, res))
            pending_results.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [vcs_pkg::DATA_W-1:0] pick_elem();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd0;
            3: return vcs_pkg::DATA_W'($urandom_range(8)) - 16'sd4;
            default: return vcs_pkg::DATA_W'($urandom);
        endcase
    endfunction

    // one random vector pair, mostly short
    task automatic send_random_vector();
        t_vec_shape                        shape;
        int                                len;
        logic signed [vcs_pkg::DATA_W-1:0] a;
        logic signed [vcs_pkg::DATA_W-1:0] b;
        shape = t_vec_shape'($urandom_range(SHAPE_NEAR));
        if ($urandom_range(99) < 85) len = $urandom_range(1, 8);
        else len = $urandom_range(9, 48);
        for (int i = 0; i < len; i++) begin
            a = pick_elem();
            b = pick_elem();
            case (shape)
                SHAPE_ZERO_A:  a = '0;
                SHAPE_ZERO_B:  b = '0;
                SHAPE_SAME:    b = a;
                SHAPE_NEGATED: b = -a;
                SHAPE_NEAR:    b = a + vcs_pkg::DATA_W'($urandom_range(6)) - 16'sd3;
                default: ;
            endcase
            send_beat(a, b, (i == len - 1), 1'b0, '0);
        end
    endtask

    // receiver stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check on each accepted beat
    always @(posedge i_clk) begin : result_check
        t_cos_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result cosine %0d degenerate %0b",
                         $time, o_cosine, o_degenerate);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_cosine !== want.cosine) begin
                    $display("%0t: cosine mismatch expected %0d actual %0d",
                             $time, want.cosine, o_cosine);
                    err_count++;
                end
                if (o_degenerate !== want.degenerate) begin
                    $display("%0t: degenerate mismatch expected %0b actual %0b",
                             $time, want.degenerate, o_degenerate);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_cos_result typed_res;
        int          phase_goal;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_a_value     = '0;
        i_b_value     = '0;
        i_last        = 1'b0;
        err_count     = 0;
        beat_count    = 0;
        dot_acc       = 0;
        norm_a_acc    = 0;
        norm_b_acc    = 0;
        send_idle_pct = 36;
        recv_idle_pct = 76;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            typed_res.cosine     = dir_rows[r].cosine;
            typed_res.degenerate = dir_rows[r].degenerate;
            send_beat(dir_rows[r].a, dir_rows[r].b, dir_rows[r].lst,
                      dir_rows[r].typed, typed_res);
        end

        // random vectors under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 36; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_goal = beat_count + PHASE_BEATS;
            while (beat_count < phase_goal) send_random_vector();
            drain_results();
        end

        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
